// File: hw/rtl/tsp_pkg.sv
// Shared widths and constants for the minimum tour cost search block.
`timescale 1ns / 1ps

package tsp_pkg;

    localparam int CITY_W   = 3;
    localparam int WEIGHT_W = 16;
    localparam int COST_W   = 19;

    typedef logic [WEIGHT_W-1:0] t_weight;
    typedef logic [COST_W-1:0]   t_cost;

    localparam t_cost COST_INF = '1;

endpackage

// File: hw/rtl/tsp_ram.sv
// Generic single write, single read RAM with registered read data.
`timescale 1ns / 1ps

module tsp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/tsp_min_tour_cost_top.sv
// Top level: edge matrix load and backtracking minimum tour cost search.
`timescale 1ns / 1ps

// Usage:
//   Command channel: a transaction is taken at a rising edge with start high and
//   busy low. Each carries one matrix edge (i_row, i_col, i_weight); a weight of
//   zero means no edge, and a row or column of CITIES or more is ignored.
//   With i_last low the block stays ready, so edges load one per cycle.
//   With i_last high the edge is stored and the search starts; busy stays high
//   until the result strobe.
//   Result: o_valid is high for exactly one cycle with o_min_cost and
//   o_tour_found; when no tour exists the cost reads 0 with the flag clear.
//   The receiver cannot stall; the result must be taken in that cycle.
//   Search: the tree is walked one node at a time through a single
//   matrix read port and one adder/comparator. Each candidate or closing edge
//   is read in S_RD and then evaluated in S_EV, and each exhausted level takes
//   one more S_RD step that returns to the parent level, or ends at the root.
//   Reset and each result clear the matrix through per-entry valid bits, so
//   the block is ready on the cycle after reset with no clearing pass.

module tsp_min_tour_cost_top #(
    parameter int CITIES = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [tsp_pkg::CITY_W-1:0]   i_row,
    input  logic [tsp_pkg::CITY_W-1:0]   i_col,
    input  logic [tsp_pkg::WEIGHT_W-1:0] i_weight,
    input  logic                         i_last,
    output logic                         o_valid,
    output logic [tsp_pkg::COST_W-1:0]   o_min_cost,
    output logic                         o_tour_found
);

    localparam int IDXW   = $clog2(CITIES);
    localparam int CNDW   = IDXW + 1;
    localparam int ADDR_W = 2 * IDXW;
    localparam int DEPTH  = 1 << ADDR_W;

    localparam logic [CNDW-1:0]           CND_END  = CNDW'(CITIES);
    localparam logic [IDXW-1:0]           LEAF_LVL = IDXW'(CITIES - 1);
    localparam logic [tsp_pkg::CITY_W:0]  CITY_LIM = (tsp_pkg::CITY_W + 1)'(CITIES);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD   = 2'd1;
    localparam logic [1:0] S_EV   = 2'd2;

    logic [1:0]             r_state;
    logic [IDXW-1:0]        r_depth;
    logic [CITIES-1:0]      r_visited;
    logic [IDXW-1:0]        r_path [CITIES];
    logic [CNDW-1:0]        r_next [CITIES];
    tsp_pkg::t_cost         r_part [CITIES];
    tsp_pkg::t_cost         r_best;
    logic [DEPTH-1:0]       r_vld;
    logic                   r_rd_vld;
    logic                   r_valid;
    tsp_pkg::t_cost         r_cost;
    logic                   r_found;

    logic                   accept;
    logic                   wr_en;
    logic [ADDR_W-1:0]      waddr;
    logic [ADDR_W-1:0]      raddr;
    tsp_pkg::t_weight       rdata;
    tsp_pkg::t_weight       w_eff;
    logic                   leaf;
    logic [IDXW-1:0]        cur;
    logic [CNDW-1:0]        cnd;
    logic                   cnd_end;
    tsp_pkg::t_cost         sum;

    assign accept = start && !busy;
    assign wr_en  = accept && ({1'b0, i_row} < CITY_LIM) && ({1'b0, i_col} < CITY_LIM);
    assign waddr  = {i_row[IDXW-1:0], i_col[IDXW-1:0]};

    assign leaf    = (r_depth == LEAF_LVL);
    assign cur     = r_path[r_depth];
    assign cnd     = r_next[r_depth];
    assign cnd_end = (cnd >= CND_END);
    assign raddr   = leaf ? {cur, IDXW'(0)} : {cur, cnd[IDXW-1:0]};
    assign w_eff   = r_rd_vld ? rdata : '0;
    assign sum     = r_part[r_depth] + tsp_pkg::COST_W'(w_eff);

    tsp_ram #(
        .WIDTH (tsp_pkg::WEIGHT_W),
        .DEPTH (DEPTH)
    ) u_matrix (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (waddr),
        .i_wdata (i_weight),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        r_rd_vld <= r_vld[raddr];
        r_cost   <= (r_best != tsp_pkg::COST_INF) ? r_best : '0;
        r_found  <= (r_best != tsp_pkg::COST_INF);
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= 1'b0;
            r_depth   <= '0;
            r_visited <= CITIES'(1);
            r_best    <= tsp_pkg::COST_INF;
            r_vld     <= '0;
        end else begin
            r_valid <= 1'b0;
            if (wr_en) begin
                r_vld[waddr] <= 1'b1;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept && i_last) begin
                        r_state   <= S_RD;
                        r_depth   <= '0;
                        r_visited <= CITIES'(1);
                        r_best    <= tsp_pkg::COST_INF;
                        r_path[0] <= '0;
                        r_next[0] <= '0;
                        r_part[0] <= '0;
                    end
                end
                S_RD: begin
                    if (leaf || !cnd_end) begin
                        r_state <= S_EV;
                    end else if (r_depth == '0) begin
                        r_state <= S_IDLE;
                        r_valid <= 1'b1;
                        r_vld   <= '0;
                    end else begin
                        r_visited[cur] <= 1'b0;
                        r_depth        <= r_depth - 1'b1;
                    end
                end
                S_EV: begin
                    r_state <= S_RD;
                    if (leaf) begin
                        if (w_eff != '0 && sum < r_best) begin
                            r_best <= sum;
                        end
                        r_visited[cur] <= 1'b0;
                        r_depth        <= r_depth - 1'b1;
                    end else begin
                        r_next[r_depth] <= cnd + 1'b1;
                        if (!r_visited[cnd[IDXW-1:0]] && w_eff != '0) begin
                            r_visited[cnd[IDXW-1:0]] <= 1'b1;
                            r_depth                  <= r_depth + 1'b1;
                            r_path[r_depth + 1'b1]   <= cnd[IDXW-1:0];
                            r_part[r_depth + 1'b1]   <= sum;
                            r_next[r_depth + 1'b1]   <= '0;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy         = (r_state != S_IDLE);
    assign o_valid      = r_valid;
    assign o_min_cost   = r_cost;
    assign o_tour_found = r_found;

    a_result_after_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == S_RD) && r_state == S_IDLE)
        else $error("result strobe without a finished search");

    a_no_tour_zero_cost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_tour_found) |-> (o_min_cost == '0))
        else $error("cost not zero when no tour found");

    a_start_city_visited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> r_visited[0])
        else $error("start city dropped from visited set");

    a_depth_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> (r_depth <= LEAF_LVL))
        else $error("search depth out of range");

    a_matrix_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_vld == '0))
        else $error("matrix not cleared after result");

endmodule
